// File: rtl/core/dar_pkg.sv
package dar_pkg;

   // Burst limits: repeats per tick and results per tick
   localparam int MAX_BURST   = 16;
   localparam int MAX_RESULTS = 16;
   localparam int BURST_CAP   = (MAX_BURST < MAX_RESULTS) ? MAX_BURST : MAX_RESULTS;
   localparam int BURST_W     = $clog2(BURST_CAP + 1);

   // Field widths
   localparam int HELD_W   = 17;
   localparam int THR_W    = 7;
   localparam int TIME_W   = 16;
   localparam int DT_W     = 10;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(70);
   localparam logic [TIME_W-1:0] DELAY_RST     = TIME_W'(300);
   localparam logic [TIME_W-1:0] PERIOD_RST    = TIME_W'(50);

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_WAIT   = 2'd1,
      PHASE_REPEAT = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_DELAY     = 2'd1,
      CSR_PERIOD    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              key_up;
      logic              key_down;
      logic              key_left;
      logic              key_right;
      logic signed [7:0] pad_x;
      logic signed [7:0] pad_y;
      logic signed [7:0] right_stick_x;
      logic signed [7:0] right_stick_y;
      logic signed [7:0] left_stick_x;
      logic signed [7:0] left_stick_y;
      logic [DT_W-1:0]   elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] direction;
      logic       last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic emit_h;
      logic emit_v;
      logic emit_cur;
      logic start_wait;
      logic accum;
      logic take_delay;
      logic take_period;
      logic switch_dir;
      logic release_dir;
      logic flush;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic      any;
      logic      has_h;
      logic      has_v;
      phase_type phase;
      logic      cur_held;
      logic      delay_hit;
      logic      period_hit;
      logic      burst_full;
      logic      pend_valid;
      logic      out_free;
   } sts_type;

endpackage

// File: rtl/core/dar_ctrl.sv
module dar_ctrl
   import dar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_PRESS_H = 7'b0000010,
      S_PRESS_V = 7'b0000100,
      S_ACCUM   = 7'b0001000,
      S_DECIDE  = 7'b0010000,
      S_BURST   = 7'b0100000,
      S_FLUSH   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      can_emit;
   logic      pressing;

   // A new result may enter the holding stage when the old one can move on
   assign can_emit  = !sts.pend_valid || sts.out_free;
   assign pressing  = (sts.phase == PHASE_IDLE) && sts.any;
   assign req_stall = (state_ff != S_IDLE);

   // Sequence one tick
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PRESS_H;
            end
         end
         S_PRESS_H: begin
            if (!pressing) begin
               state_in = S_ACCUM;
            end else if (!sts.has_h) begin
               state_in = S_PRESS_V;
            end else if (can_emit) begin
               cmd.emit_h = 1'b1;
               state_in   = S_PRESS_V;
            end
         end
         S_PRESS_V: begin
            if (!sts.has_v) begin
               cmd.start_wait = 1'b1;
               state_in       = S_ACCUM;
            end else if (can_emit) begin
               cmd.emit_v     = 1'b1;
               cmd.start_wait = 1'b1;
               state_in       = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (sts.phase != PHASE_IDLE) begin
               cmd.accum = 1'b1;
               state_in  = S_DECIDE;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_DECIDE: begin
            if (sts.cur_held) begin
               if (sts.phase == PHASE_WAIT) begin
                  if (!sts.delay_hit) begin
                     state_in = S_FLUSH;
                  end else if (can_emit) begin
                     cmd.emit_cur   = 1'b1;
                     cmd.take_delay = 1'b1;
                     state_in       = S_FLUSH;
                  end
               end else begin
                  state_in = S_BURST;
               end
            end else if (sts.any) begin
               cmd.switch_dir = 1'b1;
               state_in       = S_FLUSH;
            end else begin
               cmd.release_dir = 1'b1;
               state_in        = S_FLUSH;
            end
         end
         S_BURST: begin
            if (!sts.period_hit || sts.burst_full) begin
               state_in = S_FLUSH;
            end else if (can_emit) begin
               cmd.emit_cur    = 1'b1;
               cmd.take_period = 1'b1;
            end
         end
         S_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/dar_dpath.sv
module dar_dpath
   import dar_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_data,
   input  cmd_type              cmd,
   output sts_type              sts
);

   // Configuration
   logic [THR_W-1:0]  thr_ff;
   logic [TIME_W-1:0] delay_ff;
   logic [TIME_W-1:0] period_ff;

   // Tick inputs and block state
   logic [3:0]         dreq_ff;
   logic [DT_W-1:0]    dt_ff;
   phase_type          phase_ff, phase_in;
   dir_type            cur_ff, cur_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [BURST_W-1:0] burst_ff, burst_in;

   // Holding stage and output register
   logic    pend_valid_ff, pend_valid_in;
   dir_type pend_dir_ff, pend_dir_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [8:0] thr_pos, thr_neg;
   logic signed [8:0] px, py, rx, ry, lx, ly;
   logic [3:0]        dreq_in;
   logic [HELD_W:0]   held_sum;
   logic [HELD_W-1:0] held_sat;
   dir_type           emit_dir;
   dir_type           switch_dir;
   logic              emit;
   logic              out_free;

   // Threshold the axes into direction requests
   always_comb begin
      thr_pos = $signed({2'b00, thr_ff});
      thr_neg = -thr_pos;
      px = $signed({req_data.pad_x[7], req_data.pad_x});
      py = $signed({req_data.pad_y[7], req_data.pad_y});
      rx = $signed({req_data.right_stick_x[7], req_data.right_stick_x});
      ry = $signed({req_data.right_stick_y[7], req_data.right_stick_y});
      lx = $signed({req_data.left_stick_x[7], req_data.left_stick_x});
      ly = $signed({req_data.left_stick_y[7], req_data.left_stick_y});
      dreq_in[DIR_UP]    = req_data.key_up    || (py > thr_pos) || (ry < thr_neg)
                           || (ly < thr_neg);
      dreq_in[DIR_DOWN]  = req_data.key_down  || (py < thr_neg) || (ry > thr_pos)
                           || (ly > thr_pos);
      dreq_in[DIR_LEFT]  = req_data.key_left  || (px < thr_neg) || (rx < thr_neg)
                           || (lx < thr_neg);
      dreq_in[DIR_RIGHT] = req_data.key_right || (px > thr_pos) || (rx > thr_pos)
                           || (lx > thr_pos);
   end

   // Saturating time accumulate
   assign held_sum = {1'b0, held_ff} + {{(HELD_W + 1 - DT_W){1'b0}}, dt_ff};
   assign held_sat = held_sum[HELD_W] ? {HELD_W{1'b1}} : held_sum[HELD_W-1:0];

   // Pick the direction to emit or to switch to
   always_comb begin
      if (cmd.emit_h) begin
         emit_dir = dreq_ff[DIR_RIGHT] ? DIR_RIGHT : DIR_LEFT;
      end else if (cmd.emit_v) begin
         emit_dir = dreq_ff[DIR_DOWN] ? DIR_DOWN : DIR_UP;
      end else begin
         emit_dir = cur_ff;
      end
      if (dreq_ff[DIR_DOWN]) begin
         switch_dir = DIR_DOWN;
      end else if (dreq_ff[DIR_UP]) begin
         switch_dir = DIR_UP;
      end else if (dreq_ff[DIR_RIGHT]) begin
         switch_dir = DIR_RIGHT;
      end else begin
         switch_dir = DIR_LEFT;
      end
   end

   assign emit     = cmd.emit_h || cmd.emit_v || cmd.emit_cur;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Advance block state
   always_comb begin
      phase_in = phase_ff;
      cur_in   = cur_ff;
      held_in  = held_ff;
      burst_in = burst_ff;
      if (cmd.load) begin
         burst_in = '0;
      end
      if (cmd.emit_h || cmd.emit_v) begin
         cur_in = emit_dir;
      end
      if (cmd.switch_dir) begin
         cur_in = switch_dir;
      end
      if (cmd.start_wait) begin
         phase_in = PHASE_WAIT;
      end
      if (cmd.accum) begin
         held_in = held_sat;
      end
      if (cmd.take_delay) begin
         held_in  = held_ff - {{(HELD_W - TIME_W){1'b0}}, delay_ff};
         phase_in = PHASE_REPEAT;
      end
      if (cmd.take_period) begin
         held_in  = held_ff - {{(HELD_W - TIME_W){1'b0}}, period_ff};
         burst_in = burst_ff + BURST_W'(1);
      end
      if (cmd.release_dir) begin
         held_in  = '0;
         phase_in = PHASE_IDLE;
      end
   end

   // Hold one result back so the final one can be marked
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_dir_in   = pend_dir_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_dir_in   = emit_dir;
         if (pend_valid_ff) begin
            rsp_valid_in     = 1'b1;
            rsp_in.direction = pend_dir_ff;
            rsp_in.last      = 1'b0;
         end
      end else if (cmd.flush) begin
         pend_valid_in    = 1'b0;
         rsp_valid_in     = 1'b1;
         rsp_in.direction = pend_dir_ff;
         rsp_in.last      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= THRESHOLD_RST;
         delay_ff      <= DELAY_RST;
         period_ff     <= PERIOD_RST;
         phase_ff      <= PHASE_IDLE;
         cur_ff        <= DIR_DOWN;
         held_ff       <= '0;
         burst_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_THRESHOLD: thr_ff    <= csr_data[THR_W-1:0];
               CSR_DELAY:     delay_ff  <= csr_data;
               CSR_PERIOD:    period_ff <= csr_data;
               default:       ;
            endcase
         end
         phase_ff      <= phase_in;
         cur_ff        <= cur_in;
         held_ff       <= held_in;
         burst_ff      <= burst_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dreq_ff <= dreq_in;
         dt_ff   <= req_data.elapsed_ms;
      end
      pend_dir_ff <= pend_dir_in;
      rsp_ff      <= rsp_in;
   end

   // Report status
   always_comb begin
      sts.any        = |dreq_ff;
      sts.has_h      = dreq_ff[DIR_RIGHT] || dreq_ff[DIR_LEFT];
      sts.has_v      = dreq_ff[DIR_DOWN] || dreq_ff[DIR_UP];
      sts.phase      = phase_ff;
      sts.cur_held   = dreq_ff[cur_ff];
      sts.delay_hit  = held_ff > {{(HELD_W - TIME_W){1'b0}}, delay_ff};
      sts.period_hit = held_ff > {{(HELD_W - TIME_W){1'b0}}, period_ff};
      sts.burst_full = (burst_ff == BURST_W'(BURST_CAP));
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/direction_autorepeat_unit.sv
// Typematic auto-repeat for four directions. Each request is one tick: key bits, six axis
// positions and the milliseconds since the last tick. From idle, a held direction gives an
// immediate press (horizontal first, then vertical); after repeat_delay ms one repeat follows,
// then one every repeat_period ms, at most 16 per tick, with leftover time carried over. Each
// response carries a direction and a last flag on the final response of the tick; a tick that
// emits nothing gives no response. One request is processed at a time; the repeat loop
// subtracts the period from the held time once per cycle unless a stalled response channel
// holds it. Configuration (index 0 threshold, 1 delay, 2 period) is always ready and should be
// written only while no tick is in flight.
module direction_autorepeat_unit
   import dar_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   dar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dar_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
